// ----- rtl/lpp_pkg.sv -----
package lpp_pkg;

    localparam int SAMPLE_BITS_DEF   = 12;
    localparam int FRACTION_BITS_DEF = 8;
    localparam int SUM_BITS_DEF      = 24;

    localparam int OUT_BITS     = 24;
    localparam int GAIN_BITS    = 16;
    localparam int GAIN_FRAC    = 8;
    localparam int THRESH_BITS  = 12;
    localparam int LOST_WHOLE   = 15;
    localparam int SENSORS      = 4;

    localparam int CFG_INDEX_BITS = 8;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [CFG_INDEX_BITS-1:0] REG_DARK_THRESHOLD = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN_P         = CFG_INDEX_BITS'(1);
    localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN_I         = CFG_INDEX_BITS'(2);
    localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN_D         = CFG_INDEX_BITS'(3);

    localparam logic [THRESH_BITS-1:0] THRESH_RESET = THRESH_BITS'(150);
    localparam logic [GAIN_BITS-1:0]   GAIN_P_RESET = GAIN_BITS'(1024);
    localparam logic [GAIN_BITS-1:0]   GAIN_I_RESET = GAIN_BITS'(0);
    localparam logic [GAIN_BITS-1:0]   GAIN_D_RESET = GAIN_BITS'(0);

    typedef enum logic [1:0] {
        GAIN_SEL_P = 2'd0,
        GAIN_SEL_I = 2'd1,
        GAIN_SEL_D = 2'd2
    } gain_sel_t;

    typedef enum logic [1:0] {
        OPND_ERR  = 2'd0,
        OPND_SUM  = 2'd1,
        OPND_DIFF = 2'd2
    } opnd_sel_t;

    typedef struct packed {
        logic      load_err;
        logic      mul_en;
        gain_sel_t gain_sel;
        opnd_sel_t opnd_sel;
        logic      mul_hi;
        logic      acc_en;
        logic      finish;
    } ucode_t;

    localparam int STEP_BITS = 4;
    localparam logic [STEP_BITS-1:0] STEP_FIRST  = STEP_BITS'(0);
    localparam logic [STEP_BITS-1:0] STEP_FINISH = STEP_BITS'(8);

    localparam ucode_t UC_NOP = '{load_err: 1'b0, mul_en: 1'b0, gain_sel: GAIN_SEL_P,
                                  opnd_sel: OPND_ERR, mul_hi: 1'b0, acc_en: 1'b0,
                                  finish: 1'b0};

    // PID program: error/state update, six partial products, drain, deliver
    function automatic ucode_t ucode_rom(input logic [STEP_BITS-1:0] step);
        ucode_t uc;
        uc = UC_NOP;
        unique case (step)
            4'd0: uc.load_err = 1'b1;
            4'd1: begin uc.mul_en = 1'b1; uc.gain_sel = GAIN_SEL_P; uc.opnd_sel = OPND_ERR; end
            4'd2: begin
                uc.mul_en = 1'b1; uc.gain_sel = GAIN_SEL_P; uc.opnd_sel = OPND_ERR;
                uc.mul_hi = 1'b1; uc.acc_en = 1'b1;
            end
            4'd3: begin
                uc.mul_en = 1'b1; uc.gain_sel = GAIN_SEL_I; uc.opnd_sel = OPND_SUM;
                uc.acc_en = 1'b1;
            end
            4'd4: begin
                uc.mul_en = 1'b1; uc.gain_sel = GAIN_SEL_I; uc.opnd_sel = OPND_SUM;
                uc.mul_hi = 1'b1; uc.acc_en = 1'b1;
            end
            4'd5: begin
                uc.mul_en = 1'b1; uc.gain_sel = GAIN_SEL_D; uc.opnd_sel = OPND_DIFF;
                uc.acc_en = 1'b1;
            end
            4'd6: begin
                uc.mul_en = 1'b1; uc.gain_sel = GAIN_SEL_D; uc.opnd_sel = OPND_DIFF;
                uc.mul_hi = 1'b1; uc.acc_en = 1'b1;
            end
            4'd7: uc.acc_en = 1'b1;
            4'd8: uc.finish = 1'b1;
            default: uc = UC_NOP;
        endcase
        return uc;
    endfunction

endpackage

// ----- rtl/lpp_if.sv -----
interface lpp_sample_if #(
    parameter int SAMPLE_BITS = lpp_pkg::SAMPLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample_left_outer;
    logic [SAMPLE_BITS-1:0] sample_left_inner;
    logic [SAMPLE_BITS-1:0] sample_right_inner;
    logic [SAMPLE_BITS-1:0] sample_right_outer;

    modport source (output valid, sample_left_outer, sample_left_inner,
                    sample_right_inner, sample_right_outer, input ready);
    modport sink   (input valid, sample_left_outer, sample_left_inner,
                    sample_right_inner, sample_right_outer, output ready);
endinterface

interface lpp_result_if;
    import lpp_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [OUT_BITS-1:0] correction;
    logic                       line_lost;

    modport source (output valid, correction, line_lost, input ready);
    modport sink   (input valid, correction, line_lost, output ready);
endinterface

interface lpp_cfg_if;
    import lpp_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/line_position_pid_unit.sv -----
// One request at a time: a new request is taken only once the last result
// is registered for result_out; the sequencer holds its finish step while
// result_out is stalled. The nine-step control program runs the shared gain
// multiplier over six partial products, skipping to the finish step when no
// sensor sees the line. Reset: asynchronous, active low; clears the sequencer,
// the error history and running sum, and loads the register defaults.
module line_position_pid_unit #(
    parameter int SAMPLE_BITS   = lpp_pkg::SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS = lpp_pkg::FRACTION_BITS_DEF,
    parameter int SUM_BITS      = lpp_pkg::SUM_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    lpp_sample_if.sink          sample_in,
    lpp_result_if.source        result_out,
    lpp_cfg_if.sink             cfg
);
    import lpp_pkg::*;

    localparam int ERR_BITS   = FRACTION_BITS + 3;
    localparam int DIFF_BITS  = ERR_BITS + 1;
    localparam int HALF       = SUM_BITS / 2;
    localparam int CHUNK_BITS = SUM_BITS - HALF + 1;
    localparam int PROD_BITS  = GAIN_BITS + 1 + CHUNK_BITS;
    localparam int ACC_BITS   = SUM_BITS + GAIN_BITS + 3;
    localparam int CMP_BITS   = (SAMPLE_BITS > THRESH_BITS) ? SAMPLE_BITS : THRESH_BITS;
    localparam int THIRD_ONE  = (1 << FRACTION_BITS) / 3;
    localparam int THIRD_TWO  = (2 << FRACTION_BITS) / 3;

    localparam logic signed [ACC_BITS-1:0] OUT_MAX = ACC_BITS'((1 << (OUT_BITS - 1)) - 1);
    localparam logic signed [ACC_BITS-1:0] OUT_MIN = ~OUT_MAX;
    localparam logic signed [OUT_BITS-1:0] LOST_VALUE =
        OUT_BITS'(-(LOST_WHOLE * (1 << FRACTION_BITS)));

    // configuration
    logic [THRESH_BITS-1:0] threshold_reg;
    logic [GAIN_BITS-1:0]   gain_p_reg;
    logic [GAIN_BITS-1:0]   gain_i_reg;
    logic [GAIN_BITS-1:0]   gain_d_reg;

    // sequencer and datapath
    logic                        busy_reg;
    logic [STEP_BITS-1:0]        step_reg;
    logic [STEP_BITS-1:0]        step_next;
    logic [SENSORS-1:0]          online_reg;
    logic                        lost_reg;
    logic signed [ERR_BITS-1:0]  prev_reg;
    logic signed [SUM_BITS-1:0]  sum_reg;
    logic signed [DIFF_BITS-1:0] diff_reg;
    logic signed [ACC_BITS-1:0]  prod_reg;
    logic signed [ACC_BITS-1:0]  acc_reg;
    logic                        out_valid_reg;
    logic signed [OUT_BITS-1:0]  correction_reg;
    logic                        line_lost_reg;

    ucode_t uc;
    logic   in_fire;
    logic   out_free;

    logic [SENSORS-1:0]          online_next;
    logic signed [3:0]           wsum;
    logic [2:0]                  count;
    logic [1:0]                  abs_w;
    logic [ERR_BITS-2:0]         mag;
    logic signed [ERR_BITS-1:0]  err;
    logic signed [SUM_BITS:0]    sum_wide;
    logic signed [SUM_BITS-1:0]  sum_sat;
    logic signed [DIFF_BITS-1:0] diff_next;

    logic signed [SUM_BITS-1:0]   opnd;
    logic signed [CHUNK_BITS-1:0] chunk;
    logic signed [GAIN_BITS:0]    gain;
    logic signed [PROD_BITS-1:0]  product;
    logic signed [ACC_BITS-1:0]   prod_ext;
    logic signed [ACC_BITS-1:0]   prod_next;
    logic signed [ACC_BITS-1:0]   total;
    logic signed [OUT_BITS-1:0]   corr_sat;

    assign uc       = ucode_rom(step_reg);
    assign in_fire  = sample_in.valid && sample_in.ready;
    assign out_free = !out_valid_reg || result_out.ready;

    assign sample_in.ready    = !busy_reg;
    assign cfg.ready          = 1'b1;
    assign result_out.valid      = out_valid_reg;
    assign result_out.correction = correction_reg;
    assign result_out.line_lost  = line_lost_reg;

    // on-line classification, taken at the request
    assign online_next[0] = CMP_BITS'(sample_in.sample_left_outer)  < CMP_BITS'(threshold_reg);
    assign online_next[1] = CMP_BITS'(sample_in.sample_left_inner)  < CMP_BITS'(threshold_reg);
    assign online_next[2] = CMP_BITS'(sample_in.sample_right_inner) < CMP_BITS'(threshold_reg);
    assign online_next[3] = CMP_BITS'(sample_in.sample_right_outer) < CMP_BITS'(threshold_reg);

    // position error: weighted sum over count, truncated toward zero
    always_comb
    begin
        wsum = 4'sd0;
        if (online_reg[0]) wsum = wsum - 4'sd2;
        if (online_reg[1]) wsum = wsum - 4'sd1;
        if (online_reg[2]) wsum = wsum + 4'sd1;
        if (online_reg[3]) wsum = wsum + 4'sd2;
        count = 3'($countones(online_reg));
        abs_w = wsum[3] ? 2'(-wsum) : wsum[1:0];
        unique case (count)
            3'd1:    mag = (ERR_BITS-1)'(abs_w) << FRACTION_BITS;
            3'd2:    mag = (ERR_BITS-1)'(abs_w) << (FRACTION_BITS - 1);
            // three sensors on leave a weight of one or two
            3'd3:    mag = abs_w[1] ? (ERR_BITS-1)'(THIRD_TWO) : (ERR_BITS-1)'(THIRD_ONE);
            default: mag = '0;
        endcase
        err = wsum[3] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end

    always_comb
    begin
        sum_wide  = (SUM_BITS+1)'(sum_reg) + (SUM_BITS+1)'(err);
        diff_next = DIFF_BITS'(err) - DIFF_BITS'(prev_reg);
        if (sum_wide[SUM_BITS] != sum_wide[SUM_BITS-1])
            sum_sat = sum_wide[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}}
                                         : {1'b0, {(SUM_BITS-1){1'b1}}};
        else
            sum_sat = sum_wide[SUM_BITS-1:0];
    end

    // shared multiplier: unsigned gain times one half of the operand
    always_comb
    begin
        unique case (uc.opnd_sel)
            OPND_ERR:  opnd = SUM_BITS'(prev_reg);
            OPND_SUM:  opnd = sum_reg;
            OPND_DIFF: opnd = SUM_BITS'(diff_reg);
            default:   opnd = '0;
        endcase
        unique case (uc.gain_sel)
            GAIN_SEL_P: gain = $signed({1'b0, gain_p_reg});
            GAIN_SEL_I: gain = $signed({1'b0, gain_i_reg});
            GAIN_SEL_D: gain = $signed({1'b0, gain_d_reg});
            default:    gain = '0;
        endcase
        if (uc.mul_hi)
            chunk = CHUNK_BITS'($signed(opnd[SUM_BITS-1:HALF]));
        else
            chunk = $signed(CHUNK_BITS'({1'b0, opnd[HALF-1:0]}));
        product   = PROD_BITS'(gain) * PROD_BITS'(chunk);
        prod_ext  = ACC_BITS'(product);
        prod_next = uc.mul_hi ? (prod_ext <<< HALF) : prod_ext;
    end

    // bring Q.16 back to Q.8 rounding down, then clip
    always_comb
    begin
        total = acc_reg >>> GAIN_FRAC;
        if (total > OUT_MAX)
            corr_sat = OUT_MAX[OUT_BITS-1:0];
        else if (total < OUT_MIN)
            corr_sat = OUT_MIN[OUT_BITS-1:0];
        else
            corr_sat = total[OUT_BITS-1:0];
    end

    always_comb
    begin
        step_next = step_reg + STEP_BITS'(1);
        if (uc.load_err && lost_reg)
            step_next = STEP_FINISH;
        else if (uc.finish)
            step_next = step_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESH_RESET;
            gain_p_reg    <= GAIN_P_RESET;
            gain_i_reg    <= GAIN_I_RESET;
            gain_d_reg    <= GAIN_D_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_DARK_THRESHOLD: threshold_reg <= cfg.data[THRESH_BITS-1:0];
                REG_GAIN_P:         gain_p_reg    <= cfg.data[GAIN_BITS-1:0];
                REG_GAIN_I:         gain_i_reg    <= cfg.data[GAIN_BITS-1:0];
                REG_GAIN_D:         gain_d_reg    <= cfg.data[GAIN_BITS-1:0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= STEP_FIRST;
            out_valid_reg <= 1'b0;
            prev_reg      <= '0;
            sum_reg       <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_FIRST;
            end
            else if (busy_reg)
            begin
                step_reg <= step_next;
                if (uc.finish && out_free)
                    busy_reg <= 1'b0;
            end

            // update the error history only when the line is seen
            if (busy_reg && uc.load_err && !lost_reg)
            begin
                prev_reg <= err;
                sum_reg  <= sum_sat;
            end

            if (busy_reg && uc.finish && out_free)
                out_valid_reg <= 1'b1;
            else if (result_out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            online_reg <= online_next;
            lost_reg   <= (online_next == '0);
        end
        if (busy_reg && uc.load_err)
        begin
            diff_reg <= diff_next;
            acc_reg  <= '0;
        end
        else if (busy_reg && uc.acc_en)
            acc_reg <= acc_reg + prod_reg;
        if (busy_reg && uc.mul_en)
            prod_reg <= prod_next;
        if (busy_reg && uc.finish && out_free)
        begin
            correction_reg <= lost_reg ? LOST_VALUE : corr_sat;
            line_lost_reg  <= lost_reg;
        end
    end

endmodule

// ----- rtl/lpp_checker.sv -----
module lpp_checker #(
    parameter int FRACTION_BITS = lpp_pkg::FRACTION_BITS_DEF
) (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic signed [lpp_pkg::OUT_BITS-1:0] correction,
    input logic                                line_lost
);
    import lpp_pkg::*;

    localparam logic signed [OUT_BITS-1:0] LOST_VALUE =
        OUT_BITS'(-(LOST_WHOLE * (1 << FRACTION_BITS)));

    // one request in flight: taking one closes the input at once
    a_single_request: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input still open after a request was taken");

    // a fresh result only appears once the input has been closed for work
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without a request being worked on");

    a_lost_value: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && line_lost) |-> (correction == LOST_VALUE))
        else $error("lost-line result carries the wrong correction");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result withdrawn before it was taken");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> ($stable(correction) && $stable(line_lost)))
        else $error("stalled result changed");

endmodule

bind line_position_pid_unit lpp_checker #(.FRACTION_BITS(FRACTION_BITS)) u_lpp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (sample_in.valid),
    .in_ready   (sample_in.ready),
    .out_valid  (result_out.valid),
    .out_ready  (result_out.ready),
    .correction (result_out.correction),
    .line_lost  (result_out.line_lost)
);
